// ===== rtl/core/multiplexed_clock_display_driver_assert.svh =====
// assertion macros for the multiplexed clock display driver
// expects signals named clk and rst in the module that uses them
`ifndef MULTIPLEXED_CLOCK_DISPLAY_DRIVER_ASSERT_SVH
`define MULTIPLEXED_CLOCK_DISPLAY_DRIVER_ASSERT_SVH

// same-cycle implication
`define MCDD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCDD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mcdd_pkg.sv =====
// types, constants and small decode functions for the clock display driver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcdd_pkg;

  localparam int NUM_TIMERS = 5;
  localparam int IMG_ROWS   = 8;
  localparam int SHOWN_DIGITS = 4;

  // register indexes, also timer numbers
  localparam logic [2:0] REG_DIGIT_SCAN = 3'd0;
  localparam logic [2:0] REG_BLINK      = 3'd1;
  localparam logic [2:0] REG_CLOCK      = 3'd2;
  localparam logic [2:0] REG_ROW_SCAN   = 3'd3;
  localparam logic [2:0] REG_ROTATE     = 3'd4;

  localparam logic [15:0] PERIOD_RESET [NUM_TIMERS] = '{
    16'd100, 16'd500, 16'd1000, 16'd2, 16'd100
  };

  localparam logic [7:0] IMAGE_RESET [IMG_ROWS] = '{
    8'hE7, 8'hC3, 8'h99, 8'h99, 8'h81, 8'h81, 8'h99, 8'h99
  };

  localparam logic [4:0] HOURS_RESET   = 5'd15;
  localparam logic [5:0] MINUTES_RESET = 6'd8;
  localparam logic [5:0] SECONDS_RESET = 6'd50;

  typedef logic [15:0] period_t;

  // tens digit of a value below 64
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    begin
      if (v >= 6'd60) t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else t = 3'd0;
      return t;
    end
  endfunction

  // units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v - 6'(tens_of(v)) * 6'd10;
      return r[3:0];
    end
  endfunction

  // common-anode segment code, digits above 9 show 9
  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    begin
      case (d)
        4'd0: c = 8'hC0;
        4'd1: c = 8'hF9;
        4'd2: c = 8'hA4;
        4'd3: c = 8'hB0;
        4'd4: c = 8'h99;
        4'd5: c = 8'h92;
        4'd6: c = 8'h82;
        4'd7: c = 8'hF8;
        4'd8: c = 8'h80;
        default: c = 8'h90;
      endcase
      return c[6:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mcdd_timer.sv =====
// one countdown timer: fires when it runs out and reloads from its period
// depends on mcdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcdd_timer
  import mcdd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire period_t init,
  input  wire period_t period,
  input  wire logic    step,
  output logic         fire
);

  period_t count;

  assign fire = (count <= 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= init;
    end else if (step) begin
      count <= fire ? period : count - 16'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multiplexed_clock_display_driver.sv =====
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle unless stalled; all state updates in one pass to the result register
// the input is stalled only while a finished result waits and the output is stalled
// reset: synchronous, active high; periods, timers, clock, image and pins return
// to their start values at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "multiplexed_clock_display_driver_assert.svh"

module multiplexed_clock_display_driver
  import mcdd_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int MATRIX_ROWS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // tick
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // digit_enable_n, segments_n, dot_led, red_led, row_enable_n, column_drive,
  // clock_hour, clock_minute, clock_second
  output logic [47:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DPW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int RPW = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;

  period_t          period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fire;
  logic             accept, step;
  logic [2:0]       reg_idx;

  logic [DPW-1:0]   digit_pointer, digit_pointer_next;
  logic [RPW-1:0]   row_pointer, row_pointer_next;
  logic [4:0]       hours, hours_next;
  logic [5:0]       minutes, minutes_next;
  logic [5:0]       seconds, seconds_next;
  logic [7:0]       row_image [IMG_ROWS];

  logic [3:0]       digit_en, digit_en_next;
  logic [6:0]       seg, seg_next;
  logic             dot, dot_next, red, red_next;
  logic [7:0]       row_en, row_en_next;
  logic [7:0]       col, col_next;

  logic [DPW+2:0]   dp_ext;
  logic [RPW+3:0]   rp_ext;
  logic [3:0]       digit_val;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = accept && s_axis_tdata[0];
  assign reg_idx       = paddr[4:2];
  assign pready        = 1'b1;

  // period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) period[i] <= PERIOD_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DIGIT_SCAN: period[REG_DIGIT_SCAN] <= pwdata[15:0];
        REG_BLINK:      period[REG_BLINK]      <= pwdata[15:0];
        REG_CLOCK:      period[REG_CLOCK]      <= pwdata[15:0];
        REG_ROW_SCAN:   period[REG_ROW_SCAN]   <= pwdata[15:0];
        REG_ROTATE:     period[REG_ROTATE]     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIGIT_SCAN: prdata = {16'd0, period[REG_DIGIT_SCAN]};
      REG_BLINK:      prdata = {16'd0, period[REG_BLINK]};
      REG_CLOCK:      prdata = {16'd0, period[REG_CLOCK]};
      REG_ROW_SCAN:   prdata = {16'd0, period[REG_ROW_SCAN]};
      REG_ROTATE:     prdata = {16'd0, period[REG_ROTATE]};
      default:        prdata = 32'd0;
    endcase
  end

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    mcdd_timer u_timer (
      .clk    (clk),
      .rst    (rst),
      .init   (PERIOD_RESET[t]),
      .period (period[t]),
      .step   (step),
      .fire   (fire[t])
    );
  end

  // next state for one tick
  always_comb begin
    digit_en_next      = digit_en;
    seg_next           = seg;
    dot_next           = dot;
    red_next           = red;
    row_en_next        = row_en;
    col_next           = col;
    digit_pointer_next = digit_pointer;
    row_pointer_next   = row_pointer;
    hours_next         = hours;
    minutes_next       = minutes;
    seconds_next       = seconds;
    dp_ext             = (DPW + 3)'(digit_pointer);
    rp_ext             = (RPW + 4)'(row_pointer);

    case (dp_ext[1:0])
      2'd0:    digit_val = 4'(tens_of({1'b0, hours}));
      2'd1:    digit_val = units_of({1'b0, hours});
      2'd2:    digit_val = 4'(tens_of(minutes));
      default: digit_val = units_of(minutes);
    endcase

    if (step && fire[REG_DIGIT_SCAN]) begin
      digit_en_next = 4'hF;
      seg_next      = 7'h7F;
      if (dp_ext < (DPW + 3)'(SHOWN_DIGITS)) begin
        digit_en_next = 4'hF & ~(4'b0001 << dp_ext[1:0]);
        seg_next      = seg_code(digit_val);
      end
      digit_pointer_next = (digit_pointer == DPW'(DIGIT_COUNT - 1)) ?
                           '0 : digit_pointer + 1'b1;
    end

    if (step && fire[REG_BLINK]) begin
      dot_next = !dot;
      red_next = !red;
    end

    if (step && fire[REG_CLOCK]) begin
      seconds_next = seconds + 6'd1;
      if (seconds_next >= 6'd60) begin
        seconds_next = 6'd0;
        minutes_next = minutes + 6'd1;
      end
      if (minutes_next >= 6'd60) begin
        minutes_next = 6'd0;
        hours_next   = hours + 5'd1;
      end
      if (hours_next >= 5'd24) hours_next = 5'd0;
    end

    if (step && fire[REG_ROW_SCAN]) begin
      row_en_next = 8'hFF;
      col_next    = 8'hFF;
      if (rp_ext < (RPW + 4)'(IMG_ROWS)) begin
        row_en_next = 8'hFF & ~(8'b0000_0001 << rp_ext[2:0]);
        col_next    = row_image[rp_ext[2:0]];
      end
      row_pointer_next = (row_pointer == RPW'(MATRIX_ROWS - 1)) ?
                         '0 : row_pointer + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pointer <= '0;
      row_pointer   <= '0;
      hours         <= HOURS_RESET;
      minutes       <= MINUTES_RESET;
      seconds       <= SECONDS_RESET;
      for (int i = 0; i < IMG_ROWS; i++) row_image[i] <= IMAGE_RESET[i];
      digit_en      <= 4'd0;
      seg           <= 7'd0;
      dot           <= 1'b0;
      red           <= 1'b0;
      row_en        <= 8'd0;
      col           <= 8'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        digit_pointer <= digit_pointer_next;
        row_pointer   <= row_pointer_next;
        hours         <= hours_next;
        minutes       <= minutes_next;
        seconds       <= seconds_next;
        digit_en      <= digit_en_next;
        seg           <= seg_next;
        dot           <= dot_next;
        red           <= red_next;
        row_en        <= row_en_next;
        col           <= col_next;
        if (step && fire[REG_ROTATE]) begin
          for (int i = 0; i < IMG_ROWS; i++) begin
            row_image[i] <= {row_image[i][0], row_image[i][7:1]};
          end
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {2'b00, seconds_next, minutes_next, hours_next, col_next,
                       row_en_next, red_next, dot_next, seg_next, digit_en_next};
    end
  end

  `MCDD_ASSERT_IMPL(a_ready_when_free, !m_axis_tvalid, s_axis_tready,
                    "input stalled while result register is free")
  `MCDD_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid,
                    "accepted item produced no result")
  `MCDD_ASSERT_IMPL(a_time_range, 1'b1,
                    seconds < 6'd60 && minutes < 6'd60 && hours < 5'd24,
                    "clock time out of range")
  `MCDD_ASSERT_NEXT(a_no_tick_holds_time, accept && !s_axis_tdata[0],
                    $stable(seconds) && $stable(minutes) && $stable(hours),
                    "item without tick changed the clock")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for multiplexed_clock_display_driver: directed table, then random tick streams
// checked against an in-bench model of the five timers, clock, digit and row scans
// depends on mcdd_pkg and the multiplexed_clock_display_driver rtl
`timescale 1ns / 1ps

module tb_top;
  import mcdd_pkg::*;

  localparam int HEAVY_PCT    = 63;
  localparam int LIGHT_PCT    = 14;
  localparam int TICK_PCT     = 85;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASE_COUNT  = 8;
  localparam int SPRINT_ITEMS = 150;
  localparam int FINAL_ITEMS  = 150;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  // m_axis_tdata layout, msb first
  typedef struct packed {
    logic [1:0] pad;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [7:0] column;
    logic [7:0] row_en_n;
    logic       red;
    logic       dot;
    logic [6:0] seg_n;
    logic [3:0] digit_en_n;
  } display_t;

  typedef struct {
    row_kind_e   kind;
    logic [4:0]  addr;
    logic [31:0] data;
    logic        tick;
    bit          typed;
    display_t    want;
  } stim_row_t;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam idle_mode_e PHASE_MODES [PHASE_COUNT] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH, IDLE_RECV, IDLE_SEND
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // tick
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // digit_enable_n, segments_n, dot_led, red_led, row_enable_n, column_drive,
  // clock_hour, clock_minute, clock_second
  logic [47:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  multiplexed_clock_display_driver dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // model state
  period_t    period_reg [NUM_TIMERS];
  period_t    countdown [NUM_TIMERS];
  logic [1:0] digit_ptr;
  logic [2:0] row_ptr;
  logic [4:0] hh;
  logic [5:0] mm;
  logic [5:0] ss;
  logic [7:0] image [IMG_ROWS];
  display_t   pins;

  display_t   display_q [$];
  period_t    plan [NUM_TIMERS];
  idle_mode_e idle_mode;
  int         errors;
  int         stuck;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic display_t advance_display(input logic tick);
    logic [NUM_TIMERS-1:0] fire;
    logic [3:0]            digit_val;
    display_t              view;
    if (tick) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (countdown[t] > 16'd1) begin
          countdown[t] = countdown[t] - 16'd1;
          fire[t] = 1'b0;
        end else begin
          countdown[t] = period_reg[t];
          fire[t] = 1'b1;
        end
      end
      if (fire[REG_DIGIT_SCAN]) begin
        case (digit_ptr)
          2'd0: digit_val = 4'(hh / 10);
          2'd1: digit_val = 4'(hh % 10);
          2'd2: digit_val = 4'(mm / 10);
          default: digit_val = 4'(mm % 10);
        endcase
        if (digit_val > 4'd9) digit_val = 4'd9;
        pins.digit_en_n = ~(4'b0001 << digit_ptr);
        pins.seg_n = SEG_TABLE[digit_val][6:0];
        digit_ptr = digit_ptr + 2'd1;
      end
      if (fire[REG_BLINK]) begin
        pins.dot = ~pins.dot;
        pins.red = ~pins.red;
      end
      if (fire[REG_CLOCK]) begin
        ss = ss + 6'd1;
        if (ss >= 6'd60) begin
          ss = 6'd0;
          mm = mm + 6'd1;
        end
        if (mm >= 6'd60) begin
          mm = 6'd0;
          hh = hh + 5'd1;
        end
        if (hh >= 5'd24) hh = 5'd0;
      end
      if (fire[REG_ROW_SCAN]) begin
        pins.row_en_n = ~(8'b0000_0001 << row_ptr);
        pins.column = image[row_ptr];
        row_ptr = row_ptr + 3'd1;
      end
      if (fire[REG_ROTATE]) begin
        for (int i = 0; i < IMG_ROWS; i++) image[i] = {image[i][0], image[i][7:1]};
      end
    end
    view = pins;
    view.pad = 2'b00;
    view.hour = hh;
    view.minute = mm;
    view.second = ss;
    return view;
  endfunction

  function automatic period_t pick_period();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'd0;
      1: return 16'd1;
      2, 3, 4: return period_t'($urandom_range(4, 2));
      5, 6, 7, 8: return period_t'($urandom_range(12, 5));
      default: return period_t'($urandom_range(40, 13));
    endcase
  endfunction

  function automatic stim_row_t item_row(input logic tick, input bit typed, input display_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.addr = '0;
    row.data = '0;
    row.tick = tick;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [4:0] addr, input logic [31:0] data);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.addr = addr;
    row.data = data;
    row.tick = 1'b0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[4:2] < NUM_TIMERS) period_reg[addr[4:2]] = data[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering items and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_plan();
    drain();
    for (int t = 0; t < NUM_TIMERS; t++) apb_write({3'(t), 2'b00}, {16'($urandom), plan[t]});
  endtask

  task automatic send_item(input logic tick, input bit typed, input display_t want);
    display_t pred;
    int       pct;
    pct = (idle_mode == IDLE_SEND) ? HEAVY_PCT : (idle_mode == IDLE_BOTH) ? LIGHT_PCT : 0;
    if ($urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, tick};
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_display(tick);
    display_q.push_back(typed ? want : pred);
  endtask

  // result side: check, then choose next tready
  initial begin
    display_t want_view;
    display_t got_view;
    int       got_count;
    int       hold_left;
    int       pct;
    got_count = 0;
    hold_left = 0;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got_view = display_t'(m_axis_tdata);
        if (display_q.size() == 0) begin
          errors++;
          $display("%0t: result with no item pending, expected none got %h", $time,
                   m_axis_tdata);
        end else begin
          want_view = display_q.pop_front();
          check_field("digit_enable_n", want_view.digit_en_n, got_view.digit_en_n);
          check_field("segments_n", want_view.seg_n, got_view.seg_n);
          check_field("dot_led", want_view.dot, got_view.dot);
          check_field("red_led", want_view.red, got_view.red);
          check_field("row_enable_n", want_view.row_en_n, got_view.row_en_n);
          check_field("column_drive", want_view.column, got_view.column);
          check_field("clock_hour", want_view.hour, got_view.hour);
          check_field("clock_minute", want_view.minute, got_view.minute);
          check_field("clock_second", want_view.second, got_view.second);
        end
        got_count++;
        if (got_count == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      pct = (idle_mode == IDLE_RECV) ? HEAVY_PCT : (idle_mode == IDLE_BOTH) ? LIGHT_PCT : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // watchdog on cycles with no accepted transfer
  initial begin
    stuck = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (psel && penable)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= STUCK_LIMIT) begin
          $display("multiplexed_clock_display_driver test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t stim_table [$];
    display_t  view;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    errors = 0;
    idle_mode = IDLE_NONE;

    for (int t = 0; t < NUM_TIMERS; t++) begin
      period_reg[t] = PERIOD_RESET[t];
      countdown[t] = PERIOD_RESET[t];
    end
    for (int i = 0; i < IMG_ROWS; i++) image[i] = IMAGE_RESET[i];
    digit_ptr = '0;
    row_ptr = '0;
    hh = HOURS_RESET;
    mm = MINUTES_RESET;
    ss = SECONDS_RESET;
    pins = '0;

    // pins low after reset, clock at its start time
    view = '0;
    view.hour = HOURS_RESET;
    view.minute = MINUTES_RESET;
    view.second = SECONDS_RESET;
    stim_table.push_back(item_row(1'b0, 1'b1, view));
    stim_table.push_back(item_row(1'b1, 1'b1, view));
    // row scan fires on the second tick with row 0 of the start image
    view.row_en_n = 8'hFE;
    view.column = IMAGE_RESET[0];
    stim_table.push_back(item_row(1'b1, 1'b1, view));
    // zero period, minimum periods, upper data bits ignored
    stim_table.push_back(write_row({REG_DIGIT_SCAN, 2'b00}, 32'h0000_0000));
    stim_table.push_back(write_row({REG_BLINK, 2'b00}, 32'hFFFF_0001));
    stim_table.push_back(write_row({REG_CLOCK, 2'b00}, 32'h0000_0001));
    stim_table.push_back(write_row({REG_ROW_SCAN, 2'b00}, 32'hA5A5_0001));
    stim_table.push_back(write_row({REG_ROTATE, 2'b00}, 32'h7FFF_0001));
    // writes past the last register are ignored
    stim_table.push_back(write_row({3'(NUM_TIMERS), 2'b00}, 32'hFFFF_FFFF));
    stim_table.push_back(write_row({3'(NUM_TIMERS + 1), 2'b00}, 32'hFFFF_FFFF));
    stim_table.push_back(write_row({3'(NUM_TIMERS + 2), 2'b00}, 32'hFFFF_FFFF));
    stim_table.push_back(item_row(1'b0, 1'b0, '0));
    for (int i = 0; i < 5; i++) stim_table.push_back(item_row(1'b1, 1'b0, '0));
    stim_table.push_back(item_row(1'b0, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        drain();
        apb_write(stim_table[i].addr, stim_table[i].data);
      end else begin
        send_item(stim_table[i].tick, stim_table[i].typed, stim_table[i].want);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      for (int t = 0; t < NUM_TIMERS; t++) plan[t] = pick_period();
      write_plan();
      idle_mode = PHASE_MODES[ph];
      repeat (PHASE_ITEMS) send_item($urandom_range(99) < TICK_PCT, 1'b0, '0);
    end

    // one-tick seconds to run minute rollovers
    for (int t = 0; t < NUM_TIMERS; t++) plan[t] = pick_period();
    plan[REG_CLOCK] = 16'd1;
    write_plan();
    idle_mode = IDLE_NONE;
    repeat (SPRINT_ITEMS) send_item($urandom_range(99) < 95, 1'b0, '0);

    for (int t = 0; t < NUM_TIMERS; t++) plan[t] = 16'hFFFF;
    write_plan();
    idle_mode = IDLE_BOTH;
    repeat (FINAL_ITEMS) send_item($urandom_range(99) < TICK_PCT, 1'b0, '0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("multiplexed_clock_display_driver test passed");
    end else begin
      $display("multiplexed_clock_display_driver test failed");
    end
    $finish;
  end

endmodule
